### design/ifd_pkg.sv
// Shared types and constants of the info frame deframer.
package ifd_pkg;

  localparam int MAX_PAYLOAD_DEF = 1024;
  localparam int LEN_W           = 11;
  localparam int CFG_IDX_W       = 3;

  localparam logic [7:0] STUFF_MASK = 8'h20;

  // Result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_ACCEPT   = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;
  localparam logic [1:0] KIND_BADLEN   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ZERO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ONE = 3'd4;

  // Register reset values
  localparam logic [7:0] FLAG_RST      = 8'h7E;
  localparam logic [7:0] ESCAPE_RST    = 8'h7D;
  localparam logic [7:0] ADDRESS_RST   = 8'h03;
  localparam logic [7:0] CTRL_ZERO_RST = 8'h00;
  localparam logic [7:0] CTRL_ONE_RST  = 8'h80;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] address_byte;
    logic [7:0] info_ctrl_zero;
    logic [7:0] info_ctrl_one;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic             frame_seq;
    logic             reply_seq;
    logic [LEN_W-1:0] payload_length;
  } result_t;

endpackage

### design/ifd_cfg.sv
// Configuration register file of the info frame deframer.
module ifd_cfg import ifd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte      <= FLAG_RST;
      cfg.escape_byte    <= ESCAPE_RST;
      cfg.address_byte   <= ADDRESS_RST;
      cfg.info_ctrl_zero <= CTRL_ZERO_RST;
      cfg.info_ctrl_one  <= CTRL_ONE_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_FLAG:      cfg.flag_byte      <= wr_data;
        CFG_ESCAPE:    cfg.escape_byte    <= wr_data;
        CFG_ADDRESS:   cfg.address_byte   <= wr_data;
        CFG_CTRL_ZERO: cfg.info_ctrl_zero <= wr_data;
        CFG_CTRL_ONE:  cfg.info_ctrl_one  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### design/ifd_core.sv
// Frame hunt and body state machine: one received byte per accepted request.
module ifd_core import ifd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

  typedef enum logic [5:0] {
    ST_HUNT = 6'b000001,
    ST_FLAG = 6'b000010,
    ST_ADDR = 6'b000100,
    ST_CTRL = 6'b001000,
    ST_BODY = 6'b010000,
    ST_ESC  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic             saved_seq, saved_seq_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             expected_reply, expected_reply_next;

  logic [7:0] ctrl_sel;
  logic [7:0] body_data;

  always_comb begin
    state_next          = state;
    saved_seq_next      = saved_seq;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    running_xor_next    = running_xor;
    byte_count_next     = byte_count;
    expected_reply_next = expected_reply;

    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = 8'h00;
    res.frame_seq      = saved_seq;
    res.reply_seq      = expected_reply;
    res.payload_length = '0;

    ctrl_sel  = saved_seq ? cfg.info_ctrl_one : cfg.info_ctrl_zero;
    body_data = (state == ST_ESC) ? (rx_byte ^ STUFF_MASK) : rx_byte;

    case (state)
      ST_HUNT: begin
        if (rx_byte == cfg.flag_byte) state_next = ST_FLAG;
      end
      ST_FLAG: begin
        if (rx_byte == cfg.address_byte)   state_next = ST_ADDR;
        else if (rx_byte != cfg.flag_byte) state_next = ST_HUNT;
      end
      ST_ADDR: begin
        if (rx_byte == cfg.info_ctrl_zero) begin
          saved_seq_next = 1'b0;
          state_next     = ST_CTRL;
        end else if (rx_byte == cfg.info_ctrl_one) begin
          saved_seq_next = 1'b1;
          state_next     = ST_CTRL;
        end else if (rx_byte == cfg.flag_byte) begin
          state_next = ST_FLAG;
        end else begin
          state_next = ST_HUNT;
        end
      end
      ST_CTRL: begin
        if (rx_byte == (cfg.address_byte ^ ctrl_sel)) begin
          held_byte_next   = 8'h00;
          held_valid_next  = 1'b0;
          running_xor_next = 8'h00;
          byte_count_next  = '0;
          state_next       = ST_BODY;
        end else if (rx_byte == cfg.flag_byte) begin
          state_next = ST_FLAG;
        end else begin
          state_next = ST_HUNT;
        end
      end
      ST_BODY, ST_ESC: begin
        if (state == ST_BODY && rx_byte == cfg.escape_byte) begin
          state_next = ST_ESC;
        end else if (state == ST_BODY && rx_byte == cfg.flag_byte) begin
          // closing flag: held byte is BCC2
          res_valid          = 1'b1;
          res.payload_length = LEN_W'(byte_count);
          if (!held_valid) begin
            res.kind = KIND_BADLEN;
          end else if (held_byte == running_xor) begin
            res.kind            = KIND_ACCEPT;
            expected_reply_next = ~expected_reply;
          end else begin
            res.kind = KIND_MISMATCH;
          end
          held_byte_next   = 8'h00;
          held_valid_next  = 1'b0;
          running_xor_next = 8'h00;
          byte_count_next  = '0;
          state_next       = ST_HUNT;
        end else if (held_valid && byte_count >= CNT_MAX) begin
          // overflow: drop frame at once
          res_valid          = 1'b1;
          res.kind           = KIND_BADLEN;
          res.payload_length = LEN_W'(byte_count);
          held_byte_next     = 8'h00;
          held_valid_next    = 1'b0;
          running_xor_next   = 8'h00;
          byte_count_next    = '0;
          state_next         = ST_HUNT;
        end else begin
          if (held_valid) begin
            res_valid        = 1'b1;
            res.data_byte    = held_byte;
            running_xor_next = running_xor ^ held_byte;
            byte_count_next  = CNT_W'(byte_count + 1'b1);
          end
          held_byte_next  = body_data;
          held_valid_next = 1'b1;
          state_next      = ST_BODY;
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT;
      saved_seq      <= 1'b0;
      held_byte      <= 8'h00;
      held_valid     <= 1'b0;
      running_xor    <= 8'h00;
      byte_count     <= '0;
      expected_reply <= 1'b1;
    end else if (in_fire) begin
      state          <= state_next;
      saved_seq      <= saved_seq_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      running_xor    <= running_xor_next;
      byte_count     <= byte_count_next;
      expected_reply <= expected_reply_next;
    end
  end

endmodule

### design/ifd_outbuf.sv
// Two-entry result buffer: output register plus skid entry.
module ifd_outbuf import ifd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t dout,
  output logic    full
);

  logic    v0, v1;
  result_t buf0, buf1;
  logic    pop;

  assign pop       = v0 && !out_stall;
  assign out_valid = v0;
  assign dout      = buf0;
  assign full      = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (!v0) v0 <= 1'b1;
          else     v1 <= 1'b1;
        end
        2'b01: begin
          v0 <= v1;
          v1 <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (!v0) buf0 <= din;
        else     buf1 <= din;
      end
      2'b01: buf0 <= buf1;
      2'b11: begin
        if (v1) begin
          buf0 <= buf1;
          buf1 <= din;
        end else begin
          buf0 <= din;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/info_frame_deframer.sv
// Top level of the info frame deframer.
// Takes one received line byte per cycle while in_stall is low and gives at most one result
// per byte: a destuffed payload byte, or at the closing flag an accept, a check mismatch or
// a bad-length verdict (also on payload overflow) with the payload length and reply sequence.
// The hunt and body state machine decides each byte combinationally; results are registered
// in a two-entry output buffer, and in_stall rises only while both entries hold results that
// the receiver has not taken. Configuration writes are always ready and take effect on the
// next byte.
module info_frame_deframer import ifd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [7:0]           data_byte,
  output logic                 frame_seq,
  output logic                 reply_seq,
  output logic [LEN_W-1:0]     payload_length,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t    cfg;
  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_fire   = in_valid && !in_stall;

  ifd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ifd_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ifd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && res_valid),
    .din       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (head),
    .full      (full)
  );

  assign kind           = head.kind;
  assign data_byte      = head.data_byte;
  assign frame_seq      = head.frame_seq;
  assign reply_seq      = head.reply_seq;
  assign payload_length = head.payload_length;

endmodule

### design/ifd_checker.sv
// Port-level assertions of the info frame deframer and their bind.
module ifd_checker import ifd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       kind,
  input logic [7:0]       data_byte,
  input logic             frame_seq,
  input logic             reply_seq,
  input logic [LEN_W-1:0] payload_length
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(frame_seq) && $stable(reply_seq) && $stable(payload_length))
    else $error("stalled result changed");

  // buffer can only be full while a result is shown
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_data_no_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> payload_length == '0)
    else $error("payload byte with nonzero length");

  a_verdict_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'h00)
    else $error("frame verdict with nonzero data byte");

endmodule

bind info_frame_deframer ifd_checker u_ifd_checker (.*);

### tb/sv/tb_info_frame_deframer.sv
// Testbench for info_frame_deframer: random and directed frames checked against a deframer model.
`timescale 1ns / 1ps

module tb_info_frame_deframer;
  import ifd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic [5:0] {
    HUNT_FLAG = 6'b000001,
    GOT_FLAG  = 6'b000010,
    GOT_ADDR  = 6'b000100,
    GOT_CTRL  = 6'b001000,
    IN_BODY   = 6'b010000,
    AFTER_ESC = 6'b100000
  } hunt_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic frame_seq;
  logic reply_seq;
  logic [LEN_W-1:0] payload_length;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  info_frame_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .data_byte(data_byte), .frame_seq(frame_seq),
    .reply_seq(reply_seq), .payload_length(payload_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deframer model state
  cfg_t regs;
  hunt_t hunt;
  logic cur_seq;
  logic [7:0] held;
  logic held_ok;
  logic [7:0] run_xor;
  int body_len;
  logic reply_bit;

  result_t expected_q[$];
  logic [7:0] frame_body[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic void push_result(logic [1:0] k, logic [7:0] d, int len);
    result_t r;
    r.kind = k;
    r.data_byte = d;
    r.frame_seq = cur_seq;
    r.reply_seq = reply_bit;
    r.payload_length = len[LEN_W-1:0];
    expected_q.push_back(r);
  endfunction

  function automatic void clear_body();
    held = 8'h00;
    held_ok = 1'b0;
    run_xor = 8'h00;
    body_len = 0;
  endfunction

  function automatic void take_body_byte(logic [7:0] d);
    if (held_ok) begin
      if (body_len >= MAX_PAYLOAD_DEF) begin
        push_result(KIND_BADLEN, 8'h00, body_len);
        clear_body();
        hunt = HUNT_FLAG;
        return;
      end
      push_result(KIND_DATA, held, 0);
      run_xor ^= held;
      body_len++;
    end
    held = d;
    held_ok = 1'b1;
    hunt = IN_BODY;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] ctrl;
    case (hunt)
      HUNT_FLAG: begin
        if (b == regs.flag_byte) hunt = GOT_FLAG;
      end
      GOT_FLAG: begin
        if (b == regs.address_byte) hunt = GOT_ADDR;
        else if (b != regs.flag_byte) hunt = HUNT_FLAG;
      end
      GOT_ADDR: begin
        if (b == regs.info_ctrl_zero) begin
          cur_seq = 1'b0;
          hunt = GOT_CTRL;
        end else if (b == regs.info_ctrl_one) begin
          cur_seq = 1'b1;
          hunt = GOT_CTRL;
        end else if (b == regs.flag_byte) begin
          hunt = GOT_FLAG;
        end else begin
          hunt = HUNT_FLAG;
        end
      end
      GOT_CTRL: begin
        ctrl = cur_seq ? regs.info_ctrl_one : regs.info_ctrl_zero;
        if (b == (regs.address_byte ^ ctrl)) begin
          clear_body();
          hunt = IN_BODY;
        end else if (b == regs.flag_byte) begin
          hunt = GOT_FLAG;
        end else begin
          hunt = HUNT_FLAG;
        end
      end
      IN_BODY: begin
        if (b == regs.escape_byte) begin
          hunt = AFTER_ESC;
        end else if (b == regs.flag_byte) begin
          if (!held_ok) begin
            push_result(KIND_BADLEN, 8'h00, 0);
          end else if (held == run_xor) begin
            push_result(KIND_ACCEPT, 8'h00, body_len);
            reply_bit = ~reply_bit;
          end else begin
            push_result(KIND_MISMATCH, 8'h00, body_len);
          end
          clear_body();
          hunt = HUNT_FLAG;
        end else begin
          take_body_byte(b);
        end
      end
      AFTER_ESC: take_body_byte(b ^ STUFF_MASK);
      default: hunt = HUNT_FLAG;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result kind=%0d data=%02h fseq=%0b rseq=%0b len=%0d",
                              kind, data_byte, frame_seq, reply_seq, payload_length));
    end else begin
      want = expected_q.pop_front();
      if (kind !== want.kind || data_byte !== want.data_byte ||
          frame_seq !== want.frame_seq || reply_seq !== want.reply_seq ||
          payload_length !== want.payload_length)
        note_mismatch($sformatf({"exp kind=%0d data=%02h fseq=%0b rseq=%0b len=%0d, ",
                                 "got kind=%0d data=%02h fseq=%0b rseq=%0b len=%0d"},
                                want.kind, want.data_byte, want.frame_seq, want.reply_seq,
                                want.payload_length, kind, data_byte, frame_seq, reply_seq,
                                payload_length));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
  end

  // receiver: random stall, or a long hold when a test asks for one
  always @(negedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == regs.flag_byte || b == regs.escape_byte) begin
      send_byte(regs.escape_byte);
      send_byte(b ^ STUFF_MASK);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic send_header(input bit seq);
    logic [7:0] ctrl;
    ctrl = seq ? regs.info_ctrl_one : regs.info_ctrl_zero;
    send_byte(regs.flag_byte);
    send_byte(regs.address_byte);
    send_byte(ctrl);
    send_byte(regs.address_byte ^ ctrl);
  endtask

  // header, stuffed body from frame_body, BCC2 (optionally corrupted), closing flag
  task automatic send_frame(input bit seq, input bit corrupt);
    logic [7:0] chk;
    chk = 8'h00;
    foreach (frame_body[i]) chk ^= frame_body[i];
    if (corrupt) chk ^= 8'(1 << $urandom_range(7));
    send_header(seq);
    foreach (frame_body[i]) send_stuffed(frame_body[i]);
    send_stuffed(chk);
    send_byte(regs.flag_byte);
  endtask

  // payload bytes lean toward the flag and escape values so stuffing gets exercised
  task automatic fill_body(input int len);
    int r;
    frame_body.delete();
    repeat (len) begin
      r = $urandom_range(7);
      if (r == 0) frame_body.push_back(regs.flag_byte);
      else if (r == 1) frame_body.push_back(regs.escape_byte);
      else frame_body.push_back(8'($urandom));
    end
  endtask

  task automatic drain();
    int w;
    in_valid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && expected_q.size() != 0; w++) @(negedge clk);
    if (expected_q.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
      expected_q.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FLAG: regs.flag_byte = val;
      CFG_ESCAPE: regs.escape_byte = val;
      CFG_ADDRESS: regs.address_byte = val;
      CFG_CTRL_ZERO: regs.info_ctrl_zero = val;
      CFG_CTRL_ONE: regs.info_ctrl_one = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] flag_v, input logic [7:0] esc_v,
                            input logic [7:0] addr_v, input logic [7:0] c0_v,
                            input logic [7:0] c1_v);
    drain();
    write_reg(CFG_FLAG, flag_v);
    write_reg(CFG_ESCAPE, esc_v);
    write_reg(CFG_ADDRESS, addr_v);
    write_reg(CFG_CTRL_ZERO, c0_v);
    write_reg(CFG_CTRL_ONE, c1_v);
    // out-of-range index must not touch anything
    write_reg(CFG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_frames();
    send_idle_pct = 23;
    recv_idle_pct = 81;
    // empty body
    send_header(1'b0);
    send_byte(regs.flag_byte);
    // one-byte body: zero-length payload, BCC2 zero passes, nonzero fails
    frame_body.delete();
    send_frame(1'b1, 1'b0);
    send_header(1'b1);
    send_byte(8'h5A);
    send_byte(regs.flag_byte);
    // stuffed flag and escape, field extremes
    frame_body = '{8'h00, 8'hFF, regs.flag_byte, regs.escape_byte};
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b1);
    // header mismatches, and a flag inside the header restarting it
    send_byte(regs.flag_byte);
    send_byte(regs.address_byte ^ 8'h01);
    send_byte(regs.flag_byte);
    send_byte(regs.flag_byte);
    send_byte(regs.address_byte);
    send_byte(regs.flag_byte);
    send_byte(regs.address_byte);
    send_byte(8'h01);
    send_header(1'b0);
    frame_body.delete();
    send_byte(regs.flag_byte);
    send_byte(regs.address_byte);
    send_byte(regs.info_ctrl_one);
    send_byte(8'hFF);
    // escape right before the flag: flag becomes data, frame keeps going
    send_header(1'b0);
    send_byte(8'h41);
    send_byte(regs.escape_byte);
    send_byte(regs.flag_byte);
    send_byte(regs.flag_byte);
  endtask

  task automatic test_register_priority();
    send_idle_pct = 23;
    recv_idle_pct = 81;
    // address equal to the flag, both control values equal: sequence zero wins
    set_config(8'h7E, 8'h7D, 8'h7E, 8'h55, 8'h55);
    frame_body = '{8'h10};
    send_frame(1'b1, 1'b0);
    frame_body = '{8'h7E, 8'h2B};
    send_frame(1'b0, 1'b0);
    // flag equal to escape: escape test comes first in the body
    set_config(8'h7E, 8'h7E, 8'h03, 8'h00, 8'h80);
    send_header(1'b1);
    send_byte(8'h11);
    send_byte(8'h7E);
    send_byte(8'h22);
    send_byte(8'h7E);
    send_byte(8'h7E);
    send_byte(8'h33);
    // control zero equal to the flag
    set_config(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    frame_body = '{8'h00, 8'hFF, 8'h80};
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b0);
  endtask

  task automatic test_max_payload();
    send_idle_pct = 0;
    recv_idle_pct = 10;
    set_config(FLAG_RST, ESCAPE_RST, ADDRESS_RST, CTRL_ZERO_RST, CTRL_ONE_RST);
    fill_body(MAX_PAYLOAD_DEF);
    send_frame(1'b0, 1'b0);
    // one byte too many: cut off at the BCC2 byte
    fill_body(MAX_PAYLOAD_DEF + 1);
    send_frame(1'b1, 1'b0);
    frame_body = '{8'hA5};
    send_frame(1'b1, 1'b0);
  endtask

  task automatic broken_header(input bit seq);
    logic [7:0] hdr[4];
    int k;
    hdr[0] = regs.flag_byte;
    hdr[1] = regs.address_byte;
    hdr[2] = seq ? regs.info_ctrl_one : regs.info_ctrl_zero;
    hdr[3] = regs.address_byte ^ hdr[2];
    k = $urandom_range(3);
    for (int i = 0; i < k; i++) send_byte(hdr[i]);
    send_byte(8'($urandom));
    if ($urandom_range(1) == 1) begin
      fill_body($urandom_range(4));
      foreach (frame_body[i]) send_stuffed(frame_body[i]);
      send_byte(regs.flag_byte);
    end
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop_at;
    int pick;
    bit seq;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      seq = $urandom_range(1);
      if (pick < 70) begin
        fill_body(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8));
        send_frame(seq, $urandom_range(9) == 0);
      end else if (pick < 80) begin
        broken_header(seq);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 94) begin
        send_header(seq);
        fill_body($urandom_range(3));
        foreach (frame_body[i]) send_stuffed(frame_body[i]);
        send_byte(regs.escape_byte);
        send_byte(regs.flag_byte);
      end else begin
        send_header(seq);
        send_byte(regs.flag_byte);
      end
    end
  endtask

  task automatic test_random_phases();
    logic [7:0] f;
    logic [7:0] e;
    send_idle_pct = 23;
    recv_idle_pct = 81;
    set_config(FLAG_RST, ESCAPE_RST, ADDRESS_RST, CTRL_ZERO_RST, CTRL_ONE_RST);
    random_traffic(200);
    send_idle_pct = 81;
    recv_idle_pct = 23;
    set_config(8'h00, 8'hFF, 8'hFF, 8'h01, 8'hFE);
    random_traffic(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(8'hFF, 8'h00, 8'h00, 8'h80, 8'h01);
    random_traffic(50);
    hold_ticket++;
    random_traffic(50);
    f = 8'($urandom);
    e = f ^ 8'($urandom_range(1, 255));
    set_config(f, e, 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(100);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FLAG;
    cfg_data = 8'h00;
    regs = '{FLAG_RST, ESCAPE_RST, ADDRESS_RST, CTRL_ZERO_RST, CTRL_ONE_RST};
    hunt = HUNT_FLAG;
    cur_seq = 1'b0;
    reply_bit = 1'b1;
    clear_body();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_frames();
    test_register_priority();
    test_max_payload();
    test_random_phases();
    drain();

    if (mismatches == 0) $display("** info_frame_deframer: PASSED **");
    else $display("** info_frame_deframer: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** info_frame_deframer: FAILED **");
    $finish;
  end

endmodule
